### rtl/core/cesc_pkg.sv
package cesc_pkg;

  // Full-scale stick magnitude and the signed limits of the stick range
  localparam logic [10:0]        MAG_FULL   = 11'd1024;
  localparam logic signed [11:0] STICK_MAX  = 12'sd1024;
  localparam logic signed [11:0] STICK_MIN  = -12'sd1024;

  // Expo amount limit in percent and unity in the 1/256 scale
  localparam logic [6:0]         AMOUNT_MAX = 7'd100;
  localparam logic [8:0]         K_ONE      = 9'd256;

  // Rounding bias added before the final shift by 8
  localparam logic [19:0]        ROUND_BIAS = 20'd128;

  // Control fields that travel with each beat down the pipeline
  typedef struct packed {
    logic                valid;
    logic                pass;
    logic                mirror;
    logic                neg;
    logic signed [11:0]  x_sat;
  } ctl_t;

  // Scale an amount of 0..100 percent to 0..256
  function automatic logic [8:0] scale_amount(input logic [6:0] k);
    logic [8:0] k9;
    k9 = {2'b00, k};
    return (k9 << 1) + (k9 >> 1) + (k9 >> 4);
  endfunction

endpackage

### rtl/core/cesc_front.sv
module cesc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic signed [11:0] stick_value,
  input  logic               mirror,
  input  logic               pass,
  output cesc_pkg::ctl_t     ctl,
  output logic [10:0]        mag
);
  import cesc_pkg::*;

  logic signed [11:0] x_sat;
  logic signed [11:0] x_abs;
  logic               neg;
  logic [10:0]        m;

  // Saturate the stick to full scale and take its magnitude
  always_comb begin
    if (stick_value > STICK_MAX) begin
      x_sat = STICK_MAX;
    end else if (stick_value < STICK_MIN) begin
      x_sat = STICK_MIN;
    end else begin
      x_sat = stick_value;
    end
    neg   = x_sat[11];
    x_abs = neg ? -x_sat : x_sat;
    m     = x_abs[10:0];
  end

  // Register the beat; a mirrored curve works on the distance from full scale
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= accept;
    end
    ctl.pass   <= pass;
    ctl.mirror <= mirror;
    ctl.neg    <= neg;
    ctl.x_sat  <= x_sat;
    mag        <= mirror ? (MAG_FULL - m) : m;
  end

endmodule

### rtl/core/cesc_cubic.sv
module cesc_cubic (
  input  logic           clk,
  input  logic           rst,
  input  cesc_pkg::ctl_t ctl_in,
  input  logic [10:0]    mag,
  input  logic [8:0]     k256,
  output cesc_pkg::ctl_t ctl_out,
  output logic [11:0]    curve
);
  import cesc_pkg::*;

  ctl_t        ctl2;
  ctl_t        ctl3;
  logic [10:0] m2;
  logic [10:0] m3;
  logic [20:0] sq;
  logic [18:0] lin2;
  logic [18:0] lin3;
  logic [20:0] cube_k;
  logic [29:0] prod_k;
  logic [31:0] prod_m;
  logic [19:0] sum;
  logic [19:0] lin_prod;

  // Products for the linear term, the k-scaled square and the cube, and the rounded sum
  always_comb begin
    lin_prod = {11'd0, K_ONE - k256} * {9'd0, mag};
    prod_k   = {9'd0, sq} * {21'd0, k256};
    prod_m   = {11'd0, cube_k} * {21'd0, m3};
    sum      = {1'b0, prod_m[30:12]} + {1'b0, lin3} + ROUND_BIAS;
  end

  // Advance three stages: square, scale by k, then cube and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid    <= 1'b0;
      ctl3.valid    <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else begin
      ctl2.valid    <= ctl_in.valid;
      ctl3.valid    <= ctl2.valid;
      ctl_out.valid <= ctl3.valid;
    end
    ctl2.pass   <= ctl_in.pass;
    ctl2.mirror <= ctl_in.mirror;
    ctl2.neg    <= ctl_in.neg;
    ctl2.x_sat  <= ctl_in.x_sat;
    sq          <= {10'd0, mag} * {10'd0, mag};
    lin2        <= lin_prod[18:0];
    m2          <= mag;

    ctl3.pass   <= ctl2.pass;
    ctl3.mirror <= ctl2.mirror;
    ctl3.neg    <= ctl2.neg;
    ctl3.x_sat  <= ctl2.x_sat;
    cube_k      <= prod_k[28:8];
    lin3        <= lin2;
    m3          <= m2;

    ctl_out.pass   <= ctl3.pass;
    ctl_out.mirror <= ctl3.mirror;
    ctl_out.neg    <= ctl3.neg;
    ctl_out.x_sat  <= ctl3.x_sat;
    curve          <= sum[19:8];
  end

endmodule

### rtl/core/cubic_expo_stick_curve.sv
// Expo curve for one radio-control stick channel.
//
// Input: a beat of stick_value is taken at each rising edge with start high
// and busy low. busy is always low, so a new sample may be offered in every
// cycle; the block takes one sample per cycle without gaps.
// Output: each result is shown on shaped_value for exactly one cycle with
// done high. A result's beat passes five register stages after its input
// beat: saturation, square, scale by the amount, cube and sum, sign restore.
// The rate of one sample per cycle is set by the five-stage pipeline,
// each multiplier sitting between registers.
// Configuration: expo_amount is written at an edge with expo_amount_we high.
// Write it only while no sample is in flight. A zero amount passes the
// saturated stick through, a negative one mirrors the curve.
// Reset (rst, synchronous) clears the amount to zero and empties the
// pipeline; samples in flight are dropped. The receiver cannot stall, so
// there is no back-pressure and no result is ever held.
module cubic_expo_stick_curve (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [11:0] stick_value,
  input  logic               expo_amount_we,
  input  logic signed [7:0]  expo_amount,
  output logic               done,
  output logic signed [11:0] shaped_value
);
  import cesc_pkg::*;

  logic signed [7:0]  amount;
  logic [7:0]         amount_abs;
  logic [6:0]         k_mag;
  logic [8:0]         k256;
  logic               mirror;
  logic               pass;
  logic               accept;
  ctl_t               ctl1;
  ctl_t               ctl4;
  logic [10:0]        mag1;
  logic [11:0]        curve;
  logic [11:0]        mag_out;
  logic signed [11:0] y;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Hold the amount register
  always_ff @(posedge clk) begin
    if (rst) begin
      amount <= '0;
    end else if (expo_amount_we) begin
      amount <= expo_amount;
    end
  end

  // Saturate the amount magnitude and scale it to 1/256 units
  always_comb begin
    amount_abs = amount[7] ? (8'd0 - amount) : amount;
    k_mag      = (amount_abs > {1'b0, AMOUNT_MAX}) ? AMOUNT_MAX : amount_abs[6:0];
    k256       = scale_amount(k_mag);
    mirror     = amount[7];
    pass       = (amount == 8'sd0);
  end

  cesc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stick_value (stick_value),
    .mirror      (mirror),
    .pass        (pass),
    .ctl         (ctl1),
    .mag         (mag1)
  );

  cesc_cubic u_cubic (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl1),
    .mag     (mag1),
    .k256    (k256),
    .ctl_out (ctl4),
    .curve   (curve)
  );

  // Undo the mirror, restore the sign, or pass the stick through
  always_comb begin
    mag_out = ctl4.mirror ? ({1'b0, MAG_FULL} - curve) : curve;
    if (ctl4.pass) begin
      y = ctl4.x_sat;
    end else if (ctl4.neg) begin
      y = -$signed(mag_out);
    end else begin
      y = $signed(mag_out);
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl4.valid;
    end
    shaped_value <= y;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("result beat missing five cycles after input beat");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("result beat without matching input beat");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (shaped_value <= STICK_MAX) && (shaped_value >= STICK_MIN))
    else $error("shaped value beyond full scale");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    (done && (shaped_value != 12'sd0)) |-> (shaped_value[11] == $past(stick_value[11], 5)))
    else $error("shaped value sign differs from stick sign");

endmodule
